// ----- design/ehx_pkg.sv -----
package ehx_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int HDR_BYTES   = 40;
  localparam int CODE_COUNT  = 73;
  localparam int FLAG_BITS   = 13;

  localparam logic [15:0] TPID      = 16'h8100;
  localparam logic [15:0] ET_ARP    = 16'h0806;
  localparam logic [15:0] ET_RARP   = 16'h8035;
  localparam logic [15:0] ET_IPV4   = 16'h0800;
  localparam logic [15:0] ET_IPV6   = 16'h86DD;
  localparam logic [15:0] ET_LLDP   = 16'h88CC;
  localparam logic [15:0] ET_LENMAX = 16'd1500;

  localparam logic [7:0] PROTO_ICMP    = 8'd1;
  localparam logic [7:0] PROTO_IGMP    = 8'd2;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] PROTO_ETHERIP = 8'd97;

  localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
  localparam logic [7:0] ICMP_REDIRECT   = 8'd5;
  localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;

  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  localparam int F_DIX     = 0;
  localparam int F_SNAP    = 1;
  localparam int F_8021Q   = 2;
  localparam int F_ARP     = 3;
  localparam int F_RARP    = 4;
  localparam int F_IPV4    = 5;
  localparam int F_IPV6    = 6;
  localparam int F_LLDP    = 7;
  localparam int F_ICMP    = 8;
  localparam int F_IGMP    = 9;
  localparam int F_TCP     = 10;
  localparam int F_UDP     = 11;
  localparam int F_ETHERIP = 12;

  typedef enum logic [6:0] {
    C_ETH_DST, C_ETH_SRC, C_ETH_TYPE, C_VL_TPID, C_VL_TCI, C_VL_PRIO, C_VL_CFI,
    C_VL_VID, C_SN_LLC, C_SN_OUI, C_SN_TYPE,
    C_ARP_HRD, C_ARP_PRO, C_ARP_HLN, C_ARP_PLN, C_ARP_OP, C_ARP_SHA,
    C_ARP_SPA, C_ARP_THA, C_ARP_TPA,
    C_V4_VER, C_V4_IHL, C_V4_TOS, C_V4_LEN, C_V4_ID, C_V4_FRAG, C_V4_TTL,
    C_V4_PROTO, C_V4_CSUM, C_V4_SA, C_V4_DA,
    C_V6_VER, C_V6_TC, C_V6_FLOW, C_V6_PLEN, C_V6_NH, C_V6_HOP, C_V6_SAH,
    C_V6_SAL, C_V6_DAH, C_V6_DAL,
    C_IC_TYPE, C_IC_CODE, C_IC_CSUM, C_IC_ID, C_IC_SEQ, C_IC_GW,
    C_UD_SRC, C_UD_DST, C_UD_LEN, C_UD_CSUM,
    C_TC_SRC, C_TC_DST, C_TC_SEQ, C_TC_ACK, C_TC_OFF, C_TC_FLAGS, C_TC_WIN,
    C_TC_CSUM, C_TC_URG,
    C_IG_TYPE, C_IG_CODE, C_IG_CSUM, C_IG_GROUP,
    C_EI_VER, C_EI_OFF,
    C_L2_OFF, C_L2_LEN, C_L3_OFF, C_L3_LEN, C_L4_OFF, C_L4_LEN,
    C_FORMAT
  } field_code_t;

  typedef enum logic [4:0] {
    ST_ETH, ST_VLAN1, ST_VLANN, ST_SNAP, ST_ARP, ST_RARP, ST_IP4, ST_IP4OPT,
    ST_IP6, ST_LLDP, ST_ICMP, ST_UDP, ST_TCP, ST_TCPOPT, ST_IGMP, ST_ETHERIP,
    ST_DONE
  } parse_stage_t;

  typedef enum logic [2:0] {
    CS_RUN, CS_COMMIT, CS_FIN, CS_SCAN, CS_SHOW
  } ctrl_state_t;

  typedef struct packed {
    logic        accept;
    logic        commit_step;
    logic        finish;
    logic        fin_step;
    logic        load;
    logic        clear;
    field_code_t code;
  } ehx_cmd_t;

  typedef struct packed {
    logic         complete;
    parse_stage_t stage;
    logic         code_valid;
  } ehx_status_t;

  function automatic field_code_t commit_first(input parse_stage_t s);
    unique case (s)
      ST_ETH:               return C_ETH_DST;
      ST_VLAN1, ST_VLANN:   return C_ETH_TYPE;
      ST_SNAP:              return C_SN_LLC;
      ST_ARP, ST_RARP:      return C_ARP_HRD;
      ST_IP4, ST_IP4OPT:    return C_V4_VER;
      ST_IP6:               return C_V6_VER;
      ST_ICMP:              return C_IC_TYPE;
      ST_UDP:               return C_UD_SRC;
      ST_TCP, ST_TCPOPT:    return C_TC_SRC;
      ST_IGMP:              return C_IG_TYPE;
      ST_ETHERIP:           return C_EI_VER;
      default:              return C_FORMAT;
    endcase
  endfunction

  function automatic field_code_t commit_last(input parse_stage_t s);
    unique case (s)
      ST_ETH:               return C_ETH_TYPE;
      ST_VLAN1:             return C_VL_VID;
      ST_VLANN:             return C_ETH_TYPE;
      ST_SNAP:              return C_SN_TYPE;
      ST_ARP, ST_RARP:      return C_ARP_TPA;
      ST_IP4, ST_IP4OPT:    return C_V4_DA;
      ST_IP6:               return C_V6_DAL;
      ST_ICMP:              return C_IC_GW;
      ST_UDP:               return C_UD_CSUM;
      ST_TCP, ST_TCPOPT:    return C_TC_URG;
      ST_IGMP:              return C_IG_GROUP;
      ST_ETHERIP:           return C_EI_OFF;
      default:              return C_FORMAT;
    endcase
  endfunction

endpackage

// ----- design/ehx_frame_if.sv -----
interface ehx_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source(output valid, output data_byte, output end_of_packet, input ready);
  modport sink(input valid, input data_byte, input end_of_packet, output ready);
endinterface

// ----- design/ehx_item_if.sv -----
interface ehx_item_if;
  logic        valid;
  logic        ready;
  logic [6:0]  field_code;
  logic [63:0] field_value;
  logic        end_of_record;

  modport source(output valid, output field_code, output field_value,
                 output end_of_record, input ready);
  modport sink(input valid, input field_code, input field_value,
               input end_of_record, output ready);
endinterface

// ----- design/ehx_ctrl.sv -----
module ehx_ctrl import ehx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_eop,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ehx_status_t status,
  output ehx_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  field_code_t code;
  logic        eop_pend;
  logic        at_last;
  logic        hit;

  assign at_last = (code == commit_last(status.stage));
  assign hit     = (code == C_FORMAT) || status.code_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      CS_RUN: begin
        if (in_valid) begin
          if (status.complete) state_next = CS_COMMIT;
          else if (in_eop) state_next = CS_FIN;
        end
      end
      CS_COMMIT: begin
        if (at_last) state_next = eop_pend ? CS_FIN : CS_RUN;
      end
      CS_FIN: begin
        if (code == C_L4_LEN) state_next = CS_SCAN;
      end
      CS_SCAN: begin
        if (hit) state_next = CS_SHOW;
      end
      CS_SHOW: begin
        if (out_ready) state_next = (code == C_FORMAT) ? CS_RUN : CS_SCAN;
      end
      default: state_next = CS_RUN;
    endcase
  end

  always_comb begin
    in_ready        = (state == CS_RUN);
    out_valid       = (state == CS_SHOW);
    cmd.accept      = (state == CS_RUN) && in_valid;
    cmd.commit_step = (state == CS_COMMIT);
    cmd.finish      = (state == CS_COMMIT) && at_last;
    cmd.fin_step    = (state == CS_FIN);
    cmd.load        = (state == CS_SCAN) && hit;
    cmd.clear       = (state == CS_SHOW) && out_ready && (code == C_FORMAT);
    cmd.code        = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CS_RUN;
      code     <= C_ETH_DST;
      eop_pend <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        CS_RUN: begin
          if (in_valid) begin
            eop_pend <= in_eop;
            if (status.complete) code <= commit_first(status.stage);
            else if (in_eop) code <= C_EI_OFF;
          end
        end
        CS_COMMIT: begin
          if (at_last) code <= C_EI_OFF;
          else code <= field_code_t'(code + 7'd1);
        end
        CS_FIN: begin
          if (code == C_L4_LEN) code <= C_ETH_DST;
          else code <= field_code_t'(code + 7'd1);
        end
        CS_SCAN: begin
          if (!hit) code <= field_code_t'(code + 7'd1);
        end
        CS_SHOW: begin
          if (out_ready) begin
            if (code == C_FORMAT) code <= C_ETH_DST;
            else code <= field_code_t'(code + 7'd1);
          end
        end
        default: code <= C_ETH_DST;
      endcase
    end
  end

endmodule

// ----- design/ehx_datapath.sv -----
module ehx_datapath import ehx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  ehx_cmd_t    cmd,
  output ehx_status_t status,
  output logic [6:0]  field_code,
  output logic [63:0] field_value,
  output logic        end_of_record
);

  logic [LENGTH_BITS-1:0] bp;
  parse_stage_t           stage;
  logic [7:0]             hbi;
  logic [3:0]             hlw;
  logic [FLAG_BITS-1:0]   flags;
  logic [LENGTH_BITS-1:0] pay_start [3];
  logic [2:0]             pay_set;
  logic [7:0]             hdr [HDR_BYTES];

  logic [63:0]            vals [CODE_COUNT];
  logic [CODE_COUNT-1:0]  valid;
  logic [63:0]            rd_q;
  field_code_t            out_code;

  logic [7:0]             need;
  logic [7:0]             hbi_inc;
  logic [2:0]             live;

  // transition at the end of a header commit
  parse_stage_t           t_stage;
  logic                   t_keep;
  logic [FLAG_BITS-1:0]   t_flags;
  logic [2:0]             t_mark;
  logic [15:0]            t_et;
  logic                   t_hlw_load;
  logic [3:0]             t_hlw;
  logic                   do_after;
  logic                   do_v4;

  logic                   commit_ok;
  logic                   c_cond;
  logic [63:0]            c_val;
  logic                   f_en;
  logic [63:0]            f_val;
  logic                   we;
  logic [63:0]            wv;

  always_comb begin
    unique case (stage)
      ST_ETH:                         need = 8'd14;
      ST_VLAN1, ST_VLANN, ST_ETHERIP: need = (stage == ST_ETHERIP) ? 8'd2 : 8'd4;
      ST_SNAP, ST_ICMP, ST_UDP, ST_IGMP: need = 8'd8;
      ST_ARP, ST_RARP:                need = 8'd28;
      ST_IP4, ST_TCP:                 need = 8'd20;
      ST_IP6:                         need = 8'd40;
      ST_IP4OPT, ST_TCPOPT:           need = {2'b00, hlw, 2'b00};
      default:                        need = 8'd0;
    endcase
  end

  assign hbi_inc = hbi + 8'd1;

  assign status.complete   = (stage != ST_LLDP) && (need != 8'd0) && (hbi_inc >= need);
  assign status.stage      = stage;
  assign status.code_valid = valid[cmd.code];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      live[l] = pay_set[l] && (bp > pay_start[l]);
    end
  end

  always_comb begin
    t_stage    = ST_DONE;
    t_keep     = 1'b0;
    t_flags    = '0;
    t_mark     = '0;
    t_et       = (stage == ST_ETH) ? {hdr[12], hdr[13]} : {hdr[2], hdr[3]};
    t_hlw_load = 1'b0;
    t_hlw      = hdr[0][3:0];
    do_after   = 1'b0;
    do_v4      = 1'b0;
    unique case (stage)
      ST_ETH: begin
        if (t_et == TPID) t_stage = ST_VLAN1;
        else do_after = 1'b1;
      end
      ST_VLAN1: begin
        t_flags[F_8021Q] = 1'b1;
        do_after         = 1'b1;
      end
      ST_VLANN: begin
        do_after  = 1'b1;
      end
      ST_SNAP: begin
        t_flags[F_SNAP] = 1'b1;
        t_mark[0]       = 1'b1;
      end
      ST_ARP:  t_flags[F_ARP]  = 1'b1;
      ST_RARP: t_flags[F_RARP] = 1'b1;
      ST_IP4: begin
        t_hlw_load = 1'b1;
        if (t_hlw == MIN_HDR_WORDS) begin
          do_v4 = 1'b1;
        end else if (t_hlw > MIN_HDR_WORDS) begin
          t_stage = ST_IP4OPT;
          t_keep  = 1'b1;
        end
      end
      ST_IP4OPT: do_v4 = 1'b1;
      ST_IP6:    t_flags[F_IPV6] = 1'b1;
      ST_ICMP: begin
        t_flags[F_ICMP] = 1'b1;
        t_mark[2]       = 1'b1;
      end
      ST_UDP: begin
        t_flags[F_UDP] = 1'b1;
        t_mark[2]      = 1'b1;
      end
      ST_TCP: begin
        t_hlw_load = 1'b1;
        t_hlw      = hdr[12][7:4];
        if (hdr[12][7:4] == MIN_HDR_WORDS) begin
          t_flags[F_TCP] = 1'b1;
          t_mark[2]      = 1'b1;
        end else if (hdr[12][7:4] > MIN_HDR_WORDS) begin
          t_stage = ST_TCPOPT;
          t_keep  = 1'b1;
        end
      end
      ST_TCPOPT: begin
        t_flags[F_TCP] = 1'b1;
        t_mark[2]      = 1'b1;
      end
      ST_IGMP: t_flags[F_IGMP] = 1'b1;
      ST_ETHERIP: begin
        t_flags[F_ETHERIP] = 1'b1;
        t_mark[2]          = 1'b1;
      end
      default: t_stage = ST_DONE;
    endcase

    if (do_after) begin
      if (t_et == TPID) begin
        t_stage = ST_VLANN;
      end else if (t_et <= ET_LENMAX) begin
        t_stage = ST_SNAP;
      end else begin
        t_flags[F_DIX] = 1'b1;
        t_mark[0]      = 1'b1;
        priority case (t_et)
          ET_ARP:  t_stage = ST_ARP;
          ET_RARP: t_stage = ST_RARP;
          ET_IPV4: t_stage = ST_IP4;
          ET_IPV6: t_stage = ST_IP6;
          ET_LLDP: t_stage = ST_LLDP;
          default: t_stage = ST_DONE;
        endcase
      end
    end

    if (do_v4) begin
      t_flags[F_IPV4] = 1'b1;
      t_mark[1]       = 1'b1;
      if ({hdr[6][4:0], hdr[7]} != 13'd0) begin
        t_stage = ST_DONE;
      end else begin
        priority case (hdr[9])
          PROTO_ICMP:    t_stage = ST_ICMP;
          PROTO_IGMP:    t_stage = ST_IGMP;
          PROTO_TCP:     t_stage = ST_TCP;
          PROTO_UDP:     t_stage = ST_UDP;
          PROTO_ETHERIP: t_stage = ST_ETHERIP;
          default:       t_stage = ST_DONE;
        endcase
      end
    end
  end

  // header commit: field values from the stored header bytes
  always_comb begin
    unique case (stage)
      ST_IP4:           commit_ok = (hdr[0][3:0] == MIN_HDR_WORDS);
      ST_TCP:           commit_ok = (hdr[12][7:4] == MIN_HDR_WORDS);
      ST_LLDP, ST_DONE: commit_ok = 1'b0;
      default:          commit_ok = 1'b1;
    endcase
  end

  always_comb begin
    c_cond = 1'b1;
    c_val  = '0;
    unique case (cmd.code)
      C_ETH_DST:  c_val = 64'({hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]});
      C_ETH_SRC:  c_val = 64'({hdr[6], hdr[7], hdr[8], hdr[9], hdr[10], hdr[11]});
      C_ETH_TYPE: c_val = 64'(t_et);
      C_VL_TPID:  c_val = 64'(TPID);
      C_VL_TCI:   c_val = 64'({hdr[0], hdr[1]});
      C_VL_PRIO:  c_val = 64'(hdr[0][7:5]);
      C_VL_CFI:   c_val = 64'(hdr[0][4]);
      C_VL_VID:   c_val = 64'({hdr[0][3:0], hdr[1]});
      C_SN_LLC:   c_val = 64'({hdr[0], hdr[1], hdr[2]});
      C_SN_OUI:   c_val = 64'({hdr[3], hdr[4], hdr[5]});
      C_SN_TYPE:  c_val = 64'({hdr[6], hdr[7]});
      C_ARP_HRD:  c_val = 64'({hdr[0], hdr[1]});
      C_ARP_PRO:  c_val = 64'({hdr[2], hdr[3]});
      C_ARP_HLN:  c_val = 64'(hdr[4]);
      C_ARP_PLN:  c_val = 64'(hdr[5]);
      C_ARP_OP:   c_val = 64'({hdr[6], hdr[7]});
      C_ARP_SHA:  c_val = 64'({hdr[8], hdr[9], hdr[10], hdr[11], hdr[12], hdr[13]});
      C_ARP_SPA:  c_val = 64'({hdr[14], hdr[15], hdr[16], hdr[17]});
      C_ARP_THA:  c_val = 64'({hdr[18], hdr[19], hdr[20], hdr[21], hdr[22], hdr[23]});
      C_ARP_TPA:  c_val = 64'({hdr[24], hdr[25], hdr[26], hdr[27]});
      C_V4_VER:   c_val = 64'(hdr[0][7:4]);
      C_V4_IHL:   c_val = 64'(hdr[0][3:0]);
      C_V4_TOS:   c_val = 64'(hdr[1]);
      C_V4_LEN:   c_val = 64'({hdr[2], hdr[3]});
      C_V4_ID:    c_val = 64'({hdr[4], hdr[5]});
      C_V4_FRAG:  c_val = 64'({hdr[6], hdr[7]});
      C_V4_TTL:   c_val = 64'(hdr[8]);
      C_V4_PROTO: c_val = 64'(hdr[9]);
      C_V4_CSUM:  c_val = 64'({hdr[10], hdr[11]});
      C_V4_SA:    c_val = 64'({hdr[12], hdr[13], hdr[14], hdr[15]});
      C_V4_DA:    c_val = 64'({hdr[16], hdr[17], hdr[18], hdr[19]});
      C_V6_VER:   c_val = 64'(hdr[0][7:4]);
      C_V6_TC:    c_val = 64'({hdr[0][3:0], hdr[1][7:4]});
      C_V6_FLOW:  c_val = 64'({hdr[1][3:0], hdr[2], hdr[3]});
      C_V6_PLEN:  c_val = 64'({hdr[4], hdr[5]});
      C_V6_NH:    c_val = 64'(hdr[6]);
      C_V6_HOP:   c_val = 64'(hdr[7]);
      C_V6_SAH:   c_val = {hdr[8], hdr[9], hdr[10], hdr[11],
                           hdr[12], hdr[13], hdr[14], hdr[15]};
      C_V6_SAL:   c_val = {hdr[16], hdr[17], hdr[18], hdr[19],
                           hdr[20], hdr[21], hdr[22], hdr[23]};
      C_V6_DAH:   c_val = {hdr[24], hdr[25], hdr[26], hdr[27],
                           hdr[28], hdr[29], hdr[30], hdr[31]};
      C_V6_DAL:   c_val = {hdr[32], hdr[33], hdr[34], hdr[35],
                           hdr[36], hdr[37], hdr[38], hdr[39]};
      C_IC_TYPE:  c_val = 64'(hdr[0]);
      C_IC_CODE:  c_val = 64'(hdr[1]);
      C_IC_CSUM:  c_val = 64'({hdr[2], hdr[3]});
      C_IC_ID: begin
        c_val  = 64'({hdr[4], hdr[5]});
        c_cond = (hdr[0] == ICMP_ECHO_REPLY) || (hdr[0] == ICMP_ECHO_REQ);
      end
      C_IC_SEQ: begin
        c_val  = 64'({hdr[6], hdr[7]});
        c_cond = (hdr[0] == ICMP_ECHO_REPLY) || (hdr[0] == ICMP_ECHO_REQ);
      end
      C_IC_GW: begin
        c_val  = 64'({hdr[4], hdr[5], hdr[6], hdr[7]});
        c_cond = (hdr[0] == ICMP_REDIRECT);
      end
      C_UD_SRC:   c_val = 64'({hdr[0], hdr[1]});
      C_UD_DST:   c_val = 64'({hdr[2], hdr[3]});
      C_UD_LEN:   c_val = 64'({hdr[4], hdr[5]});
      C_UD_CSUM:  c_val = 64'({hdr[6], hdr[7]});
      C_TC_SRC:   c_val = 64'({hdr[0], hdr[1]});
      C_TC_DST:   c_val = 64'({hdr[2], hdr[3]});
      C_TC_SEQ:   c_val = 64'({hdr[4], hdr[5], hdr[6], hdr[7]});
      C_TC_ACK:   c_val = 64'({hdr[8], hdr[9], hdr[10], hdr[11]});
      C_TC_OFF:   c_val = 64'(hdr[12][7:4]);
      C_TC_FLAGS: c_val = 64'(hdr[13]);
      C_TC_WIN:   c_val = 64'({hdr[14], hdr[15]});
      C_TC_CSUM:  c_val = 64'({hdr[16], hdr[17]});
      C_TC_URG:   c_val = 64'({hdr[18], hdr[19]});
      C_IG_TYPE:  c_val = 64'(hdr[0]);
      C_IG_CODE:  c_val = 64'(hdr[1]);
      C_IG_CSUM:  c_val = 64'({hdr[2], hdr[3]});
      C_IG_GROUP: c_val = 64'({hdr[4], hdr[5], hdr[6], hdr[7]});
      C_EI_VER:   c_val = 64'({hdr[0], hdr[1]});
      default:    c_val = '0;
    endcase
  end

  // end of frame: payload offsets and lengths
  always_comb begin
    f_en  = 1'b0;
    f_val = '0;
    unique case (cmd.code)
      C_EI_OFF: begin
        f_en  = flags[F_ETHERIP];
        f_val = live[2] ? 64'(16'(pay_start[2])) : 64'd0;
      end
      C_L2_OFF: begin
        f_en  = live[0];
        f_val = 64'(pay_start[0]);
      end
      C_L2_LEN: begin
        f_en  = live[0];
        f_val = 64'(bp - pay_start[0]);
      end
      C_L3_OFF: begin
        f_en  = live[1];
        f_val = 64'(pay_start[1]);
      end
      C_L3_LEN: begin
        f_en  = live[1];
        f_val = 64'(bp - pay_start[1]);
      end
      C_L4_OFF: begin
        f_en  = live[2];
        f_val = 64'(pay_start[2]);
      end
      C_L4_LEN: begin
        f_en  = live[2];
        f_val = 64'(bp - pay_start[2]);
      end
      default: f_en = 1'b0;
    endcase
  end

  assign we = (cmd.commit_step && commit_ok && c_cond) || (cmd.fin_step && f_en);
  assign wv = cmd.fin_step ? f_val : c_val;

  always_ff @(posedge clk) begin
    if (we) vals[cmd.code] <= wv;
    if (cmd.load) begin
      rd_q     <= vals[cmd.code];
      out_code <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (stage != ST_LLDP) && (need != 8'd0) && (hbi < HDR_BYTES)) begin
      hdr[hbi[5:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= '0;
    end else if (we) begin
      valid[cmd.code] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      bp        <= '0;
      stage     <= ST_ETH;
      hbi       <= '0;
      hlw       <= '0;
      flags     <= '0;
      pay_set   <= '0;
      for (int l = 0; l < 3; l++) pay_start[l] <= '0;
    end else if (cmd.accept) begin
      if (bp != {LENGTH_BITS{1'b1}}) bp <= bp + 1'b1;
      if (stage == ST_LLDP) begin
        flags[F_LLDP] <= 1'b1;
        pay_start[1]  <= pay_start[0];
        pay_set[1]    <= pay_set[0];
        stage         <= ST_DONE;
        hbi           <= '0;
      end else if (need != 8'd0) begin
        hbi <= hbi_inc;
      end
    end else if (cmd.finish) begin
      stage <= t_stage;
      if (!t_keep) hbi <= '0;
      flags <= flags | t_flags;
      if (t_hlw_load) hlw <= t_hlw;
      for (int l = 0; l < 3; l++) begin
        if (t_mark[l]) begin
          pay_start[l] <= bp;
          pay_set[l]   <= 1'b1;
        end
      end
    end
  end

  assign field_code    = out_code;
  assign end_of_record = (out_code == C_FORMAT);
  assign field_value   = (out_code == C_FORMAT) ? 64'(flags) : rd_q;

endmodule

// ----- design/ethernet_ip_header_extractor.sv -----
// Ethernet/VLAN/SNAP/ARP/IPv4/IPv6/LLDP/L4 header extractor. Frame bytes
// enter on the frame channel one per transfer in wire order, end_of_packet
// on the last byte. While headers stream past, a byte is taken every cycle;
// the byte that completes a header holds off the input while the fields
// of that header are written into the field store, one field code at a
// time through its single write port. After the last byte the block
// writes the payload offsets and lengths, then walks all 73 codes, one per
// cycle unless a field waits to be sent, and sends each extracted field as
// a code/value transfer on the record channel, ascending by code, each
// read from the store into the output register before it is offered.
// The run ends with the format flag word, which carries end_of_record;
// the next frame is accepted once that transfer completes. A frame
// shorter than the Ethernet header yields the format word alone.
module ethernet_ip_header_extractor import ehx_pkg::*; (
  input logic         clk,
  input logic         rst,
  ehx_frame_if.sink   frame,
  ehx_item_if.source  record
);

  ehx_cmd_t    cmd;
  ehx_status_t status;

  // sequencer: byte intake, header commit, end-of-frame bookkeeping, emission
  ehx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame.valid),
    .in_eop    (frame.end_of_packet),
    .in_ready  (frame.ready),
    .out_valid (record.valid),
    .out_ready (record.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // parse state, header buffer, field store and output register
  ehx_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (frame.data_byte),
    .cmd           (cmd),
    .status        (status),
    .field_code    (record.field_code),
    .field_value   (record.field_value),
    .end_of_record (record.end_of_record)
  );

endmodule
